>>> rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants for the circular deque: word layouts, operation and
// status codes, and the command broadcast to the storage cells.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // operation codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [DATA_WIDTH-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [DATA_WIDTH-1:0] removed_value;
    logic [CNT_W-1:0]             entry_count;
  } out_word_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             push_front;  // shift toward the back, take left value
    logic             push_back;   // cell at wr_pos takes the new value
    logic             pop_front;   // shift toward the front, take right value
    logic [CNT_W-1:0] wr_pos;
    logic             tap_en;      // drive the removed value onto the tap chain
    logic [IDX_W-1:0] tap_pos;
  } cell_cmd_t;

endpackage

>>> rtl/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell
// One storage cell of the deque chain. Entries are kept in order, front in
// cell 0; a front push or front pop shifts every cell by one position.
// ----------------------------------------------------------------------------
module cdq_cell (
  input  logic                           clk,
  input  cdq_pkg::cell_cmd_t             cmd,
  input  logic [cdq_pkg::IDX_W-1:0]      cell_pos,
  input  logic [cdq_pkg::DATA_WIDTH-1:0] push_value,
  input  logic [cdq_pkg::DATA_WIDTH-1:0] from_left,
  input  logic [cdq_pkg::DATA_WIDTH-1:0] from_right,
  input  logic [cdq_pkg::DATA_WIDTH-1:0] tap_in,
  output logic [cdq_pkg::DATA_WIDTH-1:0] value_q,
  output logic [cdq_pkg::DATA_WIDTH-1:0] tap_out
);
  import cdq_pkg::*;

  logic [DATA_WIDTH-1:0] value_next;
  logic                  is_wr;
  logic                  is_tap;

  assign is_wr  = (cmd.wr_pos == {1'b0, cell_pos});
  assign is_tap = cmd.tap_en && (cmd.tap_pos == cell_pos);

  // shift or load
  always_comb begin
    value_next = value_q;
    if (cmd.push_front) begin
      value_next = from_left;
    end else if (cmd.pop_front) begin
      value_next = from_right;
    end else if (cmd.push_back && is_wr) begin
      value_next = push_value;
    end
  end

  always_ff @(posedge clk) begin
    value_q <= value_next;
  end

  // removed value travels down the tap chain
  assign tap_out = tap_in | (is_tap ? value_q : '0);

endmodule

>>> rtl/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue over a chain of storage cells with a bounded capacity.
// ----------------------------------------------------------------------------
// Each accepted operation's result is loaded into the output register.
// Throughput: one operation per cycle unless the output stalls; the chain
// shifts at most once per word. Reset clears the entry count, loads capacity
// 16; cell contents are not reset. A capacity write empties the queue.
module circular_deque_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdq_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cdq_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);
  import cdq_pkg::*;

  logic [4:0]       capacity;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] ring_size;
  logic             in_fire;
  logic             push_ok;
  logic             pop_ok;
  status_t          status;
  cell_cmd_t        cmd;
  kind_t            kind;

  logic [DATA_WIDTH-1:0] cell_val [DEPTH];
  logic [DATA_WIDTH-1:0] tap [DEPTH+1];

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign kind      = kind_t'(in_data.kind);

  // clamp capacity to 1..DEPTH
  always_comb begin
    if (capacity == 5'd0) begin
      ring_size = CNT_W'(1);
    end else if (32'(capacity) > DEPTH) begin
      ring_size = CNT_W'(DEPTH);
    end else begin
      ring_size = CNT_W'(capacity);
    end
  end

  // decode the operation
  always_comb begin
    push_ok     = 1'b0;
    pop_ok      = 1'b0;
    status      = ST_DONE;
    cmd         = '0;
    cmd.wr_pos  = count;
    case (kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (count >= ring_size) begin
          status = ST_OVERFLOW;
        end else begin
          push_ok = 1'b1;
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (count == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          pop_ok = 1'b1;
        end
      end
      default: status = ST_DONE;
    endcase
    cmd.push_front = in_fire && push_ok && (kind == KIND_PUSH_FRONT);
    cmd.push_back  = in_fire && push_ok && (kind == KIND_PUSH_BACK);
    cmd.pop_front  = in_fire && pop_ok && (kind == KIND_POP_FRONT);
    cmd.tap_en     = pop_ok;
    cmd.tap_pos    = (kind == KIND_POP_BACK) ? IDX_W'(count - CNT_W'(1)) : '0;
  end

  // count after this operation
  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + CNT_W'(1);
    end else if (pop_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  // cell chain, front entry in cell 0
  assign tap[0] = '0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_v;
    logic [DATA_WIDTH-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = in_data.value;
    end else begin : g_mid
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_inner
      assign right_v = cell_val[i+1];
    end
    cdq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_pos   (IDX_W'(i)),
      .push_value (in_data.value),
      .from_left  (left_v),
      .from_right (right_v),
      .tap_in     (tap[i]),
      .value_q    (cell_val[i]),
      .tap_out    (tap[i+1])
    );
  end

  // capacity register and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 5'(DEPTH);
      count    <= '0;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
      count    <= '0;
    end else if (in_fire) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.status        <= status;
      out_data.removed_value <= tap[DEPTH];
      out_data.entry_count   <= count_next;
    end
  end

endmodule

>>> tb/circular_deque_unit_tb.sv
// ----------------------------------------------------------------------------
// circular_deque_unit_tb
// Self-checking bench for the circular deque. A behavioral deque in the
// bench predicts status, removed value and entry count for every accepted
// operation word. Directed cases cover the field extremes, all four
// operations, wrap-around, overflow, underflow and capacity handling.
// Random traffic then runs under three handshake idling profiles.
// ----------------------------------------------------------------------------
module circular_deque_unit_tb;
  import cdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int HOLDOFF       = 3;     // settle time before a capacity write
  localparam int SEG_ITEMS     = 48;
  localparam int MAX_REPORTS   = 50;

  // DUT inputs, all driven to known values from time zero
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [4:0] cfg_data = '0;

  circular_deque_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // bench copy of the deque state
  logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
  logic [IDX_W-1:0]      head_pos;
  logic [IDX_W-1:0]      tail_pos;
  logic [CNT_W-1:0]      fill_level;
  logic [CNT_W-1:0]      ring_cap;

  out_word_t replies_due[$];

  // idling profile, percent of cycles
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  int fail_count   = 0;
  int words_sent   = 0;
  int cfg_writes   = 0;
  int n_done       = 0;
  int n_overflow   = 0;
  int n_underflow  = 0;
  int stall_cycles = 0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // capacity write: clamp into 1..DEPTH and empty the ring
  task automatic set_ring_cap(input logic [4:0] raw);
    if (raw == 5'd0) begin
      ring_cap = CNT_W'(1);
    end else if (raw > 5'(DEPTH)) begin
      ring_cap = CNT_W'(DEPTH);
    end else begin
      ring_cap = CNT_W'(raw);
    end
    head_pos   = '0;
    tail_pos   = '0;
    fill_level = '0;
  endtask

  // apply one operation and return the reply it produces
  function automatic out_word_t deque_reply(input in_word_t w);
    out_word_t r;
    r = '0;
    r.status = ST_DONE;
    if (w.kind == KIND_PUSH_BACK || w.kind == KIND_PUSH_FRONT) begin
      if (fill_level >= ring_cap) begin
        r.status = ST_OVERFLOW;
      end else begin
        if (fill_level == 0) begin
          head_pos    = '0;
          tail_pos    = '0;
          ring_mem[0] = w.value;
        end else if (w.kind == KIND_PUSH_BACK) begin
          tail_pos = (tail_pos + 1 >= ring_cap) ? '0 : tail_pos + 1'b1;
          ring_mem[tail_pos] = w.value;
        end else begin
          head_pos = (head_pos == 0 || head_pos >= ring_cap) ?
                     IDX_W'(ring_cap - 1) : head_pos - 1'b1;
          ring_mem[head_pos] = w.value;
        end
        fill_level = fill_level + 1'b1;
      end
    end else begin
      if (fill_level == 0) begin
        r.status = ST_UNDERFLOW;
      end else if (w.kind == KIND_POP_FRONT) begin
        r.removed_value = ring_mem[head_pos];
        if (fill_level == 1) begin
          head_pos = '0;
          tail_pos = '0;
        end else begin
          head_pos = (head_pos + 1 >= ring_cap) ? '0 : head_pos + 1'b1;
        end
        fill_level = fill_level - 1'b1;
      end else begin
        r.removed_value = ring_mem[tail_pos];
        if (fill_level == 1) begin
          head_pos = '0;
          tail_pos = '0;
        end else begin
          tail_pos = (tail_pos == 0 || tail_pos >= ring_cap) ?
                     IDX_W'(ring_cap - 1) : tail_pos - 1'b1;
        end
        fill_level = fill_level - 1'b1;
      end
    end
    r.entry_count = fill_level;
    return r;
  endfunction

  // ----------------------------------------------------------------- drivers

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // send one operation word; returns right after the accepting edge
  task automatic send_op(input kind_t k, input logic [DATA_WIDTH-1:0] v);
    in_word_t w;
    w.kind  = k;
    w.value = v;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    replies_due.push_back(deque_reply(w));
    words_sent++;
  endtask

  // stop sending, wait for every reply, then idle for the holdoff time
  task automatic drain_replies(input int holdoff);
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (holdoff) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] raw);
    drain_replies(HOLDOFF);
    cfg_valid <= 1'b1;
    cfg_data  <= raw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    set_ring_cap(raw);
    cfg_writes++;
  endtask

  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // ----------------------------------------------------------------- checker

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) $error("reply word with nothing pending");
      end else begin
        exp_w = replies_due.pop_front();
        if (out_data.status != exp_w.status) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("status: expected %0d, got %0d", exp_w.status, out_data.status);
        end
        if (out_data.removed_value != exp_w.removed_value) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("removed_value: expected %0d, got %0d",
                   exp_w.removed_value, out_data.removed_value);
        end
        if (out_data.entry_count != exp_w.entry_count) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("entry_count: expected %0d, got %0d",
                   exp_w.entry_count, out_data.entry_count);
        end
        case (exp_w.status)
          ST_DONE:     n_done++;
          ST_OVERFLOW: n_overflow++;
          default:     n_underflow++;
        endcase
      end
    end
  end

  // watchdog: no handshake on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("circular_deque_unit_tb: FAIL");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------- tests

  // ops on the reset-default capacity, value extremes, both ends
  task automatic test_basic_ops();
    send_op(KIND_POP_FRONT, $urandom);
    send_op(KIND_POP_BACK, $urandom);
    send_op(KIND_PUSH_BACK, 32'h7fff_ffff);
    send_op(KIND_PUSH_FRONT, 32'h8000_0000);
    send_op(KIND_PUSH_BACK, 32'h0000_0000);
    send_op(KIND_PUSH_FRONT, 32'hffff_ffff);
    send_op(KIND_POP_FRONT, $urandom);
    send_op(KIND_POP_BACK, $urandom);
    send_op(KIND_POP_FRONT, $urandom);
    send_op(KIND_POP_BACK, $urandom);   // last entry leaves
    send_op(KIND_POP_BACK, $urandom);   // empty again
  endtask

  // wrap of both indices and overflow on a two-slot ring
  task automatic test_wrap_overflow();
    write_capacity(5'd2);
    send_op(KIND_PUSH_FRONT, 32'h0000_0001);
    send_op(KIND_PUSH_FRONT, 32'h0000_0002);  // head wraps to the top slot
    send_op(KIND_PUSH_BACK, 32'h0000_0003);
    send_op(KIND_PUSH_FRONT, 32'h0000_0004);
    send_op(KIND_POP_BACK, $urandom);
    send_op(KIND_POP_BACK, $urandom);
    send_op(KIND_PUSH_BACK, 32'h0000_0005);
    send_op(KIND_PUSH_BACK, 32'h0000_0006);
    send_op(KIND_POP_FRONT, $urandom);
  endtask

  // zero and oversized capacity, and the flush on a capacity write
  task automatic test_capacity_limits();
    write_capacity(5'd0);                     // behaves as one slot
    send_op(KIND_PUSH_BACK, 32'ha5a5_a5a5);
    send_op(KIND_PUSH_FRONT, 32'h5a5a_5a5a);
    send_op(KIND_POP_FRONT, $urandom);
    send_op(KIND_PUSH_BACK, 32'h1234_5678);
    write_capacity(5'd31);                    // clamps to DEPTH, empties ring
    send_op(KIND_POP_FRONT, $urandom);
  endtask

  // random traffic: bursts biased toward filling or draining the ring, or balanced
  task automatic test_random_traffic(input int idle_in, input int idle_out,
                                     input bit pause_mid);
    logic [4:0] cap_plan [10];
    int         push_pct;
    kind_t      k;
    cap_plan = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd5, 5'd0, 5'd17, 5'd8, 5'd31, 5'd16};
    sender_idle_pct = idle_in;
    recv_stall_pct  = idle_out;
    for (int seg = 0; seg < 10; seg++) begin
      if (seg == 9) begin
        write_capacity(5'($urandom_range(31)));
      end else begin
        write_capacity(cap_plan[seg]);
      end
      push_pct = 50;
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (i % 12 == 0) begin
          case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
          endcase
        end
        if (pause_mid && seg == 4 && i == SEG_ITEMS / 2) begin
          drain_replies(1);
        end
        if ($urandom_range(99) < push_pct) begin
          k = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        end else begin
          k = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
        end
        send_op(k, pick_value());
      end
    end
  endtask

  // ------------------------------------------------------------------- main

  initial begin
    set_ring_cap(5'(DEPTH));
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_wrap_overflow();
    test_capacity_limits();
    test_random_traffic(21, 74, 1'b1);
    test_random_traffic(74, 21, 1'b0);
    test_random_traffic(0, 0, 1'b0);

    drain_replies(5);
    $display("covered %0d operation words over %0d capacity writes (0, 1..16, clamped 17..31)",
             words_sent, cfg_writes);
    $display("replies: %0d done, %0d overflow, %0d underflow; %0d mismatches",
             n_done, n_overflow, n_underflow, fail_count);
    if (fail_count == 0) begin
      $display("circular_deque_unit_tb: PASS");
    end else begin
      $display("circular_deque_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
